[hw/rtl/r16eu_pkg.sv]
package r16eu_pkg;

	typedef enum logic [2:0] {
		KIND_R   = 3'd0,
		KIND_I   = 3'd1,
		KIND_B   = 3'd2,
		KIND_S   = 3'd3,
		KIND_L   = 3'd4,
		KIND_J   = 3'd5,
		KIND_U   = 3'd6,
		KIND_SYS = 3'd7
	} kind_t;

	// R-type function codes.
	localparam logic [3:0] R_ADD  = 4'h0;
	localparam logic [3:0] R_SUB  = 4'h1;
	localparam logic [3:0] R_SLT  = 4'h2;
	localparam logic [3:0] R_SLTU = 4'h3;
	localparam logic [3:0] R_SLL  = 4'h4;
	localparam logic [3:0] R_SRL  = 4'h5;
	localparam logic [3:0] R_SRA  = 4'h6;
	localparam logic [3:0] R_OR   = 4'h7;
	localparam logic [3:0] R_AND  = 4'h8;
	localparam logic [3:0] R_XOR  = 4'h9;
	localparam logic [3:0] R_MV   = 4'hA;
	localparam logic [3:0] R_JR   = 4'hB;
	localparam logic [3:0] R_JALR = 4'hC;

	// I-type function codes.
	localparam logic [3:0] I_ADDI  = 4'h0;
	localparam logic [3:0] I_SLTI  = 4'h1;
	localparam logic [3:0] I_SLTUI = 4'h2;
	localparam logic [3:0] I_SHIFT = 4'h3;
	localparam logic [3:0] I_ORI   = 4'h4;
	localparam logic [3:0] I_ANDI  = 4'h5;
	localparam logic [3:0] I_XORI  = 4'h6;
	localparam logic [3:0] I_LI    = 4'h7;

	// Shift types in the raw immediate.
	localparam logic [2:0] SH_LEFT  = 3'd1;
	localparam logic [2:0] SH_LOGIC = 3'd2;
	localparam logic [2:0] SH_ARITH = 3'd4;

	// Branch function codes.
	localparam logic [3:0] B_EQ  = 4'h0;
	localparam logic [3:0] B_NE  = 4'h1;
	localparam logic [3:0] B_EZ  = 4'h2;
	localparam logic [3:0] B_NZ  = 4'h3;
	localparam logic [3:0] B_LT  = 4'h4;
	localparam logic [3:0] B_GE  = 4'h5;
	localparam logic [3:0] B_LTU = 4'h6;
	localparam logic [3:0] B_GEU = 4'h7;

	// Store and load function codes.
	localparam logic [3:0] ST_BYTE  = 4'h0;
	localparam logic [3:0] ST_WORD  = 4'h1;
	localparam logic [3:0] LD_BYTE  = 4'h0;
	localparam logic [3:0] LD_WORD  = 4'h1;
	localparam logic [3:0] LD_UBYTE = 4'h4;

	localparam logic [15:0] PC_RESET  = 16'h0020;
	localparam logic [15:0] SP_RESET  = 16'hEFFE;
	localparam logic [2:0]  SP_INDEX  = 3'd2;
	localparam logic [15:0] PC_STEP   = 16'd2;

	function automatic logic [15:0] reg_reset_value(input logic [2:0] idx);
		logic [15:0] v;
		v = (idx == SP_INDEX) ? SP_RESET : 16'h0000;
		return v;
	endfunction

endpackage

[hw/rtl/risc16_execute_unit.sv]
// Channel  | Dir | Handshake                  | Payload
// instr    | in  | instr_valid, instr_stall   | kind, funct, dest_reg, src1_reg, src2_reg,
//          |     |                            | imm_value, imm_raw, link_flag, upper_flag
// result   | out | result_valid, result_stall | next_pc, reg_written, written_index,
//          |     |                            | written_value, branch_taken
//
// An accepted item sits in the input stage while its operands, read from the register
// file at acceptance, are available; it completes into the result register when that is free.
// Non-load items sustain one item per cycle while the result is not stalled; byte and word
// loads add a phase for the registered read of the two byte-wide data memory banks.
// arst_n clears the pipeline valids and register valid bits and resets the PC to PC_RESET.
// A stalled result holds the result register; one more item can wait in the input stage.
module risc16_execute_unit #(
	parameter int MEM_BYTES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        instr_valid,
	output logic        instr_stall,
	input  logic [2:0]  kind,
	input  logic [3:0]  funct,
	input  logic [2:0]  dest_reg,
	input  logic [2:0]  src1_reg,
	input  logic [2:0]  src2_reg,
	input  logic signed [15:0] imm_value,
	input  logic [6:0]  imm_raw,
	input  logic        link_flag,
	input  logic        upper_flag,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [15:0] next_pc,
	output logic        reg_written,
	output logic [2:0]  written_index,
	output logic [15:0] written_value,
	output logic        branch_taken
);
	import r16eu_pkg::*;

	localparam int ADDR_W = $clog2(MEM_BYTES);
	localparam int ROW_W  = ADDR_W - 1;
	localparam int ROWS   = MEM_BYTES / 2;

	// Register file storage with per-entry valid bits.
	logic [15:0] rf_mem [8];
	logic [7:0]  rf_vld_q;

	// Data memory split into even and odd byte banks.
	logic [7:0] mem_even [ROWS];
	logic [7:0] mem_odd  [ROWS];
	logic [7:0] rd_even_q;
	logic [7:0] rd_odd_q;

	// Input stage.
	logic        valid_s1;
	logic        phase_q;
	kind_t       kind_s1;
	logic [3:0]  funct_s1;
	logic [2:0]  dest_s1;
	logic signed [15:0] imm_s1;
	logic [6:0]  raw_s1;
	logic        link_s1;
	logic        upper_s1;
	logic [15:0] opa_s1;
	logic [15:0] opb_s1;

	logic [15:0] pc_q;

	// Result register.
	logic        result_valid_q;
	logic [15:0] next_pc_q;
	logic        reg_written_q;
	logic [2:0]  written_index_q;
	logic [15:0] written_value_q;
	logic        branch_taken_q;

	logic        accept;
	logic        out_free;
	logic        is_load;
	logic        issue;
	logic        done;
	kind_t       kind_in;
	logic [2:0]  ra_addr;
	logic        wr_en;

	logic        wr;
	logic        taken;
	logic        cond;
	logic [15:0] val;
	logic [15:0] pc_nxt;
	logic [15:0] pc_inc;
	logic [15:0] imm_u;
	logic [15:0] addr;
	logic [ADDR_W-1:0] mem_idx;
	logic [ROW_W-1:0]  row;
	logic [ROW_W-1:0]  row_even;
	logic        lsb;
	logic        st_even;
	logic        st_odd;
	logic [7:0]  st_data_even;
	logic [7:0]  st_data_odd;
	logic [7:0]  ld_lo;
	logic [7:0]  ld_hi;
	logic [2:0]  sh_type;
	logic [3:0]  sh_amt;

	assign kind_in  = kind_t'(kind);
	assign out_free = !result_valid_q || !result_stall;
	assign is_load  = (kind_s1 == KIND_L) && (funct_s1 inside {LD_BYTE, LD_WORD, LD_UBYTE});
	assign issue    = valid_s1 && is_load && !phase_q;
	assign done     = valid_s1 && (!is_load || phase_q) && out_free;
	assign instr_stall = valid_s1 && !done;
	assign accept   = instr_valid && !instr_stall;
	assign wr_en    = done && wr;

	// R and I items take their first operand from dest_reg, the others from src1_reg.
	assign ra_addr = (kind_in == KIND_R || kind_in == KIND_I) ? dest_reg : src1_reg;

	assign pc_inc  = pc_q + PC_STEP;
	assign imm_u   = imm_s1;
	assign addr    = opa_s1 + imm_u;
	assign mem_idx = addr[ADDR_W-1:0];
	assign row     = mem_idx[ADDR_W-1:1];
	assign lsb     = mem_idx[0];
	// An odd word address takes its high byte from the next even row.
	assign row_even = lsb ? row + ROW_W'(1) : row;
	assign ld_lo    = lsb ? rd_odd_q : rd_even_q;
	assign ld_hi    = lsb ? rd_even_q : rd_odd_q;
	assign st_data_even = lsb ? opb_s1[15:8] : opb_s1[7:0];
	assign st_data_odd  = lsb ? opb_s1[7:0] : opb_s1[15:8];
	assign sh_type = raw_s1[6:4];
	assign sh_amt  = raw_s1[3:0];

	always_comb begin
		wr      = 1'b0;
		taken   = 1'b0;
		cond    = 1'b0;
		val     = 16'h0000;
		pc_nxt  = pc_inc;
		st_even = 1'b0;
		st_odd  = 1'b0;
		case (kind_s1)
			KIND_R: begin
				wr = 1'b1;
				case (funct_s1)
					R_ADD:  val = opa_s1 + opb_s1;
					R_SUB:  val = opa_s1 - opb_s1;
					R_SLT:  val = {15'd0, $signed(opa_s1) < $signed(opb_s1)};
					R_SLTU: val = {15'd0, opa_s1 < opb_s1};
					R_SLL:  val = opa_s1 << opb_s1[3:0];
					R_SRL:  val = opa_s1 >> opb_s1[3:0];
					R_SRA:  val = $unsigned($signed(opa_s1) >>> opb_s1[3:0]);
					R_OR:   val = opa_s1 | opb_s1;
					R_AND:  val = opa_s1 & opb_s1;
					R_XOR:  val = opa_s1 ^ opb_s1;
					R_MV:   val = opb_s1;
					R_JR: begin
						wr     = 1'b0;
						pc_nxt = opa_s1;
						taken  = 1'b1;
					end
					R_JALR: begin
						val    = pc_inc;
						pc_nxt = opb_s1;
						taken  = 1'b1;
					end
					default: wr = 1'b0;
				endcase
			end
			KIND_I: begin
				wr = 1'b1;
				case (funct_s1)
					I_ADDI:  val = opa_s1 + imm_u;
					I_SLTI:  val = {15'd0, $signed(opa_s1) < imm_s1};
					I_SLTUI: val = {15'd0, opa_s1 < imm_u};
					I_SHIFT: begin
						case (sh_type)
							SH_LEFT:  val = opa_s1 << sh_amt;
							SH_LOGIC: val = opa_s1 >> sh_amt;
							SH_ARITH: val = $unsigned($signed(opa_s1) >>> sh_amt);
							default:  wr = 1'b0;
						endcase
					end
					I_ORI:   val = opa_s1 | {9'd0, raw_s1};
					I_ANDI:  val = opa_s1 & imm_u;
					I_XORI:  val = opa_s1 ^ imm_u;
					I_LI:    val = imm_u;
					default: wr = 1'b0;
				endcase
			end
			KIND_B: begin
				case (funct_s1)
					B_EQ:    cond = opa_s1 == opb_s1;
					B_NE:    cond = opa_s1 != opb_s1;
					B_EZ:    cond = opa_s1 == 16'h0000;
					B_NZ:    cond = opa_s1 != 16'h0000;
					B_LT:    cond = $signed(opa_s1) < $signed(opb_s1);
					B_GE:    cond = $signed(opa_s1) >= $signed(opb_s1);
					B_LTU:   cond = opa_s1 < opb_s1;
					B_GEU:   cond = opa_s1 >= opb_s1;
					default: cond = 1'b0;
				endcase
				if (cond) begin
					pc_nxt = pc_inc + imm_u;
					taken  = 1'b1;
				end
			end
			KIND_S: begin
				case (funct_s1)
					ST_BYTE: begin
						st_even = !lsb;
						st_odd  = lsb;
					end
					ST_WORD: begin
						st_even = 1'b1;
						st_odd  = 1'b1;
					end
					default: begin
						st_even = 1'b0;
						st_odd  = 1'b0;
					end
				endcase
			end
			KIND_L: begin
				case (funct_s1)
					LD_BYTE: begin
						val = {{8{ld_lo[7]}}, ld_lo};
						wr  = 1'b1;
					end
					LD_WORD: begin
						val = {ld_hi, ld_lo};
						wr  = 1'b1;
					end
					LD_UBYTE: begin
						val = {8'h00, ld_lo};
						wr  = 1'b1;
					end
					default: wr = 1'b0;
				endcase
			end
			KIND_J: begin
				if (link_s1) begin
					val = pc_inc;
					wr  = 1'b1;
				end
				pc_nxt = pc_inc + imm_u;
				taken  = 1'b1;
			end
			KIND_U: begin
				val = upper_s1 ? pc_q + imm_u : imm_u;
				wr  = 1'b1;
			end
			default: wr = 1'b0;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			phase_q        <= 1'b0;
			pc_q           <= PC_RESET;
			rf_vld_q       <= 8'h00;
			result_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (done) begin
				valid_s1 <= 1'b0;
			end
			if (done) begin
				phase_q <= 1'b0;
			end else if (issue) begin
				phase_q <= 1'b1;
			end
			if (done) begin
				pc_q <= pc_nxt;
			end
			if (wr_en) begin
				rf_vld_q[dest_s1] <= 1'b1;
			end
			if (done) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Input stage payload; operands bypass a register written at the same edge.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= kind_in;
			funct_s1 <= funct;
			dest_s1  <= dest_reg;
			imm_s1   <= imm_value;
			raw_s1   <= imm_raw;
			link_s1  <= link_flag;
			upper_s1 <= upper_flag;
			if (wr_en && dest_s1 == ra_addr) begin
				opa_s1 <= val;
			end else begin
				opa_s1 <= rf_vld_q[ra_addr] ? rf_mem[ra_addr] : reg_reset_value(ra_addr);
			end
			if (wr_en && dest_s1 == src2_reg) begin
				opb_s1 <= val;
			end else begin
				opb_s1 <= rf_vld_q[src2_reg] ? rf_mem[src2_reg] : reg_reset_value(src2_reg);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			rf_mem[dest_s1] <= val;
		end
	end

	always_ff @(posedge clk) begin
		if (done && st_even) begin
			mem_even[row_even] <= st_data_even;
		end
		if (issue) begin
			rd_even_q <= mem_even[row_even];
		end
	end

	always_ff @(posedge clk) begin
		if (done && st_odd) begin
			mem_odd[row] <= st_data_odd;
		end
		if (issue) begin
			rd_odd_q <= mem_odd[row];
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			next_pc_q       <= pc_nxt;
			reg_written_q   <= wr;
			written_index_q <= wr ? dest_s1 : 3'd0;
			written_value_q <= wr ? val : 16'h0000;
			branch_taken_q  <= taken;
		end
	end

	assign result_valid  = result_valid_q;
	assign next_pc       = next_pc_q;
	assign reg_written   = reg_written_q;
	assign written_index = written_index_q;
	assign written_value = written_value_q;
	assign branch_taken  = branch_taken_q;

endmodule
